// ===== hdl/pdrq_pkg.sv =====
// shared types and codes for the port demux receive queues
package pdrq_pkg;

  localparam int PORT_W    = 16;
  localparam int BUF_W     = 10;
  localparam int LEN_W     = 16;
  localparam int HWADDR_W  = 48;
  localparam int SLOT_W    = 4;
  localparam int DROP_W    = 32;
  localparam int CFG_DW    = 32;
  localparam int CFG_AW    = 3;

  localparam logic [1:0] ACT_ARRIVE  = 2'd0;
  localparam logic [1:0] ACT_RECEIVE = 2'd1;
  localparam logic [1:0] ACT_REMOVE  = 2'd2;
  localparam logic [1:0] ACT_NONE    = 2'd3;

  localparam logic CFG_REG_MAX_PORT = 1'b0;

  typedef enum logic [2:0] {
    ST_ENQ      = 3'd0,
    ST_NOSLOT   = 3'd1,
    ST_FULL     = 3'd2,
    ST_DEQ      = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_BADPORT  = 3'd5,
    ST_REMOVED  = 3'd6,
    ST_NOTFOUND = 3'd7
  } status_t;

  typedef struct packed {
    logic [1:0]          action;
    logic [PORT_W-1:0]   port_number;
    logic [BUF_W-1:0]    buffer_handle;
    logic [LEN_W-1:0]    msg_length;
    logic [HWADDR_W-1:0] sender_hwaddr;
    logic [PORT_W-1:0]   sender_port;
    logic [LEN_W-1:0]    max_length;
  } item_t;

  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   slot_index;
    logic [BUF_W-1:0]    out_buffer;
    logic [LEN_W-1:0]    out_length;
    logic [HWADDR_W-1:0] out_hwaddr;
    logic [PORT_W-1:0]   out_sender_port;
    logic [DROP_W-1:0]   dropped_count;
  } result_t;

  // one queued frame descriptor
  typedef struct packed {
    logic [BUF_W-1:0]    buffer;
    logic [LEN_W-1:0]    length;
    logic [HWADDR_W-1:0] hwaddr;
    logic [PORT_W-1:0]   sender_port;
  } entry_t;

  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_res_t;

endpackage

// ===== hdl/pdrq_cmp_unit.sv =====
// shared 16-bit compare unit: equality and unsigned less-than
module pdrq_cmp_unit (
  input  logic [pdrq_pkg::PORT_W-1:0] opa,
  input  logic [pdrq_pkg::PORT_W-1:0] opb,
  output pdrq_pkg::cmp_res_t          res
);

  always_comb begin
    res.eq = (opa == opb);
    res.lt = (opa < opb);
  end

endmodule

// ===== hdl/pdrq_ring_store.sv =====
// descriptor ring storage, one write port and one registered read port
module pdrq_ring_store #(
  parameter int AW    = 7,
  parameter int DEPTH = 128
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  pdrq_pkg::entry_t     wdata,
  input  logic [AW-1:0]        raddr,
  output pdrq_pkg::entry_t     rdata
);

  pdrq_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/port_demux_receive_queues_unit.sv =====
// top level: per-port receive queue demux with slot scan sequencer
//
// one request channel (item_valid / item_stall / item) carries arrive, receive
// and remove actions; one response channel (result_valid / result_stall /
// result) returns exactly one result beat per request beat
// a request beat is taken only while the sequencer is idle; the port number is
// then range checked, the slot table is scanned one slot per cycle through a
// single shared comparator, and the chosen slot's ring state and descriptor
// are read from registered memories
// a rejected port or a no-op goes from the range check straight to the result
// beat; a remove or a port with no slot ends after the scan; an arrive or a
// receive also reads and updates the slot's ring state, and a dequeue then
// reads the descriptor and clips its length; the next request beat is taken
// the cycle after the result beat leaves
// while the receiver stalls, the result beat holds and no request is taken
// reset clears the slot in-use bits, the drop counter and the sequencer and
// sets max_port_number to 65535; no clearing pass is needed since a slot's
// ring state is written when the slot is claimed
// max_port_number sits at byte address 0 of the apb-style port
module port_demux_receive_queues_unit #(
  parameter int PORT_SLOTS  = 16,
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          item_valid,
  output logic                          item_stall,
  input  pdrq_pkg::item_t               item,
  // response channel
  output logic                          result_valid,
  input  logic                          result_stall,
  output pdrq_pkg::result_t             result,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pdrq_pkg::CFG_AW-1:0]   paddr,
  input  logic [pdrq_pkg::CFG_DW-1:0]   pwdata,
  output logic [pdrq_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int SW  = (PORT_SLOTS > 1) ? $clog2(PORT_SLOTS) : 1;
  localparam int NW  = $clog2(PORT_SLOTS + 1);
  localparam int PW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int ED  = PORT_SLOTS * QUEUE_DEPTH;
  localparam int EW  = $clog2(ED);

  localparam logic [NW-1:0] SCAN_END  = NW'(PORT_SLOTS);
  localparam logic [CW-1:0] Q_FULL    = CW'(QUEUE_DEPTH);
  localparam logic [PW-1:0] PTR_LAST  = PW'(QUEUE_DEPTH - 1);
  localparam logic [EW-1:0] Q_STRIDE  = EW'(QUEUE_DEPTH);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CHECK = 8'b0000_0010,
    S_SCAN  = 8'b0000_0100,
    S_QRD   = 8'b0000_1000,
    S_ACT   = 8'b0001_0000,
    S_ERD   = 8'b0010_0000,
    S_CLIP  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  // ring bookkeeping of one slot
  typedef struct packed {
    logic [CW-1:0] count;
    logic [PW-1:0] head;
    logic [PW-1:0] tail;
  } qstate_t;

  state_t                          state;
  pdrq_pkg::item_t                 req;
  logic [pdrq_pkg::PORT_W-1:0]     max_port;
  logic [PORT_SLOTS-1:0]           in_use;
  logic [pdrq_pkg::DROP_W-1:0]     drop_counter;

  logic [NW-1:0]                   scan;
  logic                            free_found;
  logic [SW-1:0]                   free_slot;
  logic [SW-1:0]                   slot;
  logic [EW-1:0]                   ring_raddr;

  pdrq_pkg::status_t               res_status;
  logic [SW-1:0]                   res_slot;
  logic [pdrq_pkg::BUF_W-1:0]      res_buffer;
  logic [pdrq_pkg::LEN_W-1:0]      res_length;
  logic [pdrq_pkg::HWADDR_W-1:0]   res_hwaddr;
  logic [pdrq_pkg::PORT_W-1:0]     res_sport;

  // slot port table and ring state memories
  logic [pdrq_pkg::PORT_W-1:0]     port_mem [PORT_SLOTS];
  logic [pdrq_pkg::PORT_W-1:0]     port_rd;
  logic [SW-1:0]                   port_raddr;
  qstate_t                         qs_mem [PORT_SLOTS];
  qstate_t                         qs_rd;

  // sequencer decode
  logic                            accept;
  logic [SW-1:0]                   scan_idx;
  logic                            scan_cmp;
  logic                            scan_hit;
  logic                            scan_last;
  logic                            free_vld;
  logic [SW-1:0]                   free_cand;
  logic                            claim;
  logic                            is_arrive;
  logic                            is_receive;
  logic                            q_full;
  logic                            q_empty;
  logic                            qs_we;
  logic [SW-1:0]                   qs_waddr;
  qstate_t                         qs_wdata;
  logic                            ring_we;
  logic [EW-1:0]                   ring_base;
  logic [EW-1:0]                   ring_addr;
  pdrq_pkg::entry_t                ring_wdata;
  pdrq_pkg::entry_t                ring_rd;
  logic                            cfg_write;

  // shared comparator operands
  logic [pdrq_pkg::PORT_W-1:0]     cmp_a;
  logic [pdrq_pkg::PORT_W-1:0]     cmp_b;
  pdrq_pkg::cmp_res_t              cmp_res;

  pdrq_cmp_unit u_cmp (
    .opa (cmp_a),
    .opb (cmp_b),
    .res (cmp_res)
  );

  always_comb begin
    case (state)
      S_CHECK: begin
        // max_port < port means a rejected port
        cmp_a = max_port;
        cmp_b = req.port_number;
      end
      S_SCAN: begin
        cmp_a = port_rd;
        cmp_b = req.port_number;
      end
      S_CLIP: begin
        cmp_a = ring_rd.length;
        cmp_b = req.max_length;
      end
      default: begin
        cmp_a = '0;
        cmp_b = '0;
      end
    endcase
  end

  assign accept     = item_valid && !item_stall;
  assign item_stall = (state != S_IDLE);
  assign is_arrive  = (req.action == pdrq_pkg::ACT_ARRIVE);
  assign is_receive = (req.action == pdrq_pkg::ACT_RECEIVE);

  // scan compares the slot read in the previous cycle
  always_comb begin
    scan_idx  = SW'(scan - NW'(1));
    scan_cmp  = (state == S_SCAN) && (scan != '0);
    scan_hit  = scan_cmp && in_use[scan_idx] && cmp_res.eq;
    scan_last = (scan == SCAN_END);
    free_vld  = free_found || (scan_cmp && !in_use[scan_idx]);
    free_cand = free_found ? free_slot : scan_idx;
    claim     = scan_cmp && !scan_hit && scan_last
                && (req.action != pdrq_pkg::ACT_REMOVE) && free_vld;
    port_raddr = scan_last ? '0 : SW'(scan);
  end

  // ring state update for the current slot
  always_comb begin
    q_full    = (qs_rd.count >= Q_FULL);
    q_empty   = (qs_rd.count == '0);
    ring_base = EW'(slot) * Q_STRIDE;
    ring_addr = ring_base + EW'(is_arrive ? qs_rd.tail : qs_rd.head);
    ring_we   = (state == S_ACT) && is_arrive && !q_full;
    qs_we     = 1'b0;
    qs_waddr  = slot;
    qs_wdata  = qs_rd;
    if (claim) begin
      qs_we    = 1'b1;
      qs_waddr = free_cand;
      qs_wdata = '0;
    end else if (state == S_ACT) begin
      if (is_arrive && !q_full) begin
        qs_we         = 1'b1;
        qs_wdata.count = qs_rd.count + CW'(1);
        qs_wdata.tail  = (qs_rd.tail == PTR_LAST) ? '0 : qs_rd.tail + PW'(1);
      end else if (is_receive && !q_empty) begin
        qs_we         = 1'b1;
        qs_wdata.count = qs_rd.count - CW'(1);
        qs_wdata.head  = (qs_rd.head == PTR_LAST) ? '0 : qs_rd.head + PW'(1);
      end
    end
  end

  always_comb begin
    ring_wdata.buffer      = req.buffer_handle;
    ring_wdata.length      = req.msg_length;
    ring_wdata.hwaddr      = req.sender_hwaddr;
    ring_wdata.sender_port = req.sender_port;
  end

  pdrq_ring_store #(
    .AW    (EW),
    .DEPTH (ED)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_addr),
    .wdata (ring_wdata),
    .raddr (ring_raddr),
    .rdata (ring_rd)
  );

  always_ff @(posedge clk) begin
    if (claim) begin
      port_mem[free_cand] <= req.port_number;
    end
    port_rd <= port_mem[port_raddr];
  end

  always_ff @(posedge clk) begin
    if (qs_we) begin
      qs_mem[qs_waddr] <= qs_wdata;
    end
    qs_rd <= qs_mem[slot];
  end

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready
                     && (paddr[2] == pdrq_pkg::CFG_REG_MAX_PORT);
  assign prdata    = (paddr[2] == pdrq_pkg::CFG_REG_MAX_PORT)
                     ? pdrq_pkg::CFG_DW'(max_port) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_port <= '1;
    end else if (cfg_write) begin
      max_port <= pwdata[pdrq_pkg::PORT_W-1:0];
    end
  end

  // control: sequencer, in-use bits, drop counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      in_use       <= '0;
      drop_counter <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (req.action == pdrq_pkg::ACT_NONE) begin
            state <= S_OUT;
          end else if (cmp_res.lt) begin
            if (is_arrive) begin
              drop_counter <= drop_counter + pdrq_pkg::DROP_W'(1);
            end
            state <= S_OUT;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_hit) begin
            if (req.action == pdrq_pkg::ACT_REMOVE) begin
              in_use[scan_idx] <= 1'b0;
              state            <= S_OUT;
            end else begin
              state <= S_QRD;
            end
          end else if (scan_last) begin
            if (claim) begin
              in_use[free_cand] <= 1'b1;
              state             <= S_QRD;
            end else begin
              if (is_arrive) begin
                drop_counter <= drop_counter + pdrq_pkg::DROP_W'(1);
              end
              state <= S_OUT;
            end
          end
        end
        S_QRD: begin
          state <= S_ACT;
        end
        S_ACT: begin
          if (is_arrive && q_full) begin
            drop_counter <= drop_counter + pdrq_pkg::DROP_W'(1);
          end
          if (is_receive && !q_empty) begin
            state <= S_ERD;
          end else begin
            state <= S_OUT;
          end
        end
        S_ERD: begin
          state <= S_CLIP;
        end
        S_CLIP: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (!result_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload: captured request, scan registers and result fields
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          req        <= item;
          res_status <= pdrq_pkg::ST_NOTFOUND;
          res_slot   <= '0;
          res_buffer <= '0;
          res_length <= '0;
          res_hwaddr <= '0;
          res_sport  <= '0;
        end
      end
      S_CHECK: begin
        scan       <= '0;
        free_found <= 1'b0;
        free_slot  <= '0;
        if (req.action != pdrq_pkg::ACT_NONE && cmp_res.lt) begin
          res_status <= pdrq_pkg::ST_BADPORT;
          if (is_arrive) begin
            res_buffer <= req.buffer_handle;
          end
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          slot     <= scan_idx;
          res_slot <= scan_idx;
          if (req.action == pdrq_pkg::ACT_REMOVE) begin
            res_status <= pdrq_pkg::ST_REMOVED;
          end
        end else if (scan_last) begin
          if (claim) begin
            slot     <= free_cand;
            res_slot <= free_cand;
          end else if (req.action != pdrq_pkg::ACT_REMOVE) begin
            res_status <= pdrq_pkg::ST_NOSLOT;
            if (is_arrive) begin
              res_buffer <= req.buffer_handle;
            end
          end
        end else begin
          scan <= scan + NW'(1);
          if (scan_cmp && !free_found && !in_use[scan_idx]) begin
            free_found <= 1'b1;
            free_slot  <= scan_idx;
          end
        end
      end
      S_ACT: begin
        ring_raddr <= ring_addr;
        if (is_arrive) begin
          if (q_full) begin
            res_status <= pdrq_pkg::ST_FULL;
            res_buffer <= req.buffer_handle;
          end else begin
            res_status <= pdrq_pkg::ST_ENQ;
          end
        end else if (q_empty) begin
          res_status <= pdrq_pkg::ST_EMPTY;
        end
      end
      S_CLIP: begin
        res_status <= pdrq_pkg::ST_DEQ;
        res_buffer <= ring_rd.buffer;
        res_length <= cmp_res.lt ? ring_rd.length : req.max_length;
        res_hwaddr <= ring_rd.hwaddr;
        res_sport  <= ring_rd.sender_port;
      end
      default: begin
      end
    endcase
  end

  // response beat; the drop counter does not move while a result waits
  assign result_valid = (state == S_OUT);
  always_comb begin
    result.status          = res_status;
    result.slot_index      = pdrq_pkg::SLOT_W'(res_slot);
    result.out_buffer      = res_buffer;
    result.out_length      = res_length;
    result.out_hwaddr      = res_hwaddr;
    result.out_sender_port = res_sport;
    result.dropped_count   = drop_counter;
  end

  // no request is taken while a result beat is pending
  a_no_accept_on_pending: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> item_stall)
    else $error("request taken while result pending");

  // drop counter only ever steps by one
  a_drop_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && drop_counter != $past(drop_counter))
      |-> drop_counter == $past(drop_counter) + pdrq_pkg::DROP_W'(1))
    else $error("drop counter jumped");

  // ring occupancy read back never exceeds the ring depth
  a_ring_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACT) |-> (qs_rd.count <= Q_FULL))
    else $error("ring count beyond depth");

endmodule
